[src/csp_pkg.sv]
// Shared constants and helpers for the cron line parser.
package csp_pkg;

    localparam int CHAR_W   = 8;
    localparam int MIN_W    = 60;
    localparam int HOUR_W   = 24;
    localparam int DAY_W    = 31;
    localparam int MON_W    = 12;
    localparam int WDAY_W   = 7;
    localparam int STATUS_W = 3;
    localparam int ACC_W    = 64;
    localparam int VAL_W    = 7;
    localparam int NUM_W    = 8;
    localparam int FLD_W    = 3;
    localparam int BIT_W    = 8;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STAR_STEP = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FIRST     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SECOND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_TOKEN  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STEP      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SEP       = 3'd6;

    localparam logic [FLD_W-1:0] FLD_MIN  = 3'd0;
    localparam logic [FLD_W-1:0] FLD_HOUR = 3'd1;
    localparam logic [FLD_W-1:0] FLD_DAY  = 3'd2;
    localparam logic [FLD_W-1:0] FLD_MON  = 3'd3;
    localparam logic [FLD_W-1:0] FLD_WDAY = 3'd4;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'd42;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'd44;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'd45;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'd47;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;

    function automatic logic [NUM_W-1:0] fld_lo(input logic [FLD_W-1:0] f);
        case (f)
            FLD_DAY, FLD_MON: fld_lo = 8'd1;
            default:          fld_lo = 8'd0;
        endcase
    endfunction

    function automatic logic [NUM_W-1:0] fld_hi(input logic [FLD_W-1:0] f);
        case (f)
            FLD_MIN:  fld_hi = 8'd59;
            FLD_HOUR: fld_hi = 8'd23;
            FLD_DAY:  fld_hi = 8'd31;
            FLD_MON:  fld_hi = 8'd12;
            default:  fld_hi = 8'd6;
        endcase
    endfunction

    function automatic logic [23:0] name_of(input logic [FLD_W-1:0] f,
                                            input logic [3:0] k);
        logic [23:0] r;
        r = 24'h0;
        if (f == FLD_MON) begin
            case (k)
                4'd0:  r = "jan";
                4'd1:  r = "feb";
                4'd2:  r = "mar";
                4'd3:  r = "apr";
                4'd4:  r = "may";
                4'd5:  r = "jun";
                4'd6:  r = "jul";
                4'd7:  r = "aug";
                4'd8:  r = "sep";
                4'd9:  r = "oct";
                4'd10: r = "nov";
                4'd11: r = "dec";
                default: r = 24'h0;
            endcase
        end else begin
            case (k)
                4'd0: r = "sun";
                4'd1: r = "mon";
                4'd2: r = "tue";
                4'd3: r = "wed";
                4'd4: r = "thu";
                4'd5: r = "fri";
                4'd6: r = "sat";
                default: r = 24'h0;
            endcase
        end
        name_of = r;
    endfunction

endpackage

[src/cron_schedule_spec_parser_top.sv]
// Cron line parser: character stream in, five field masks and status out.
//
//  channel | signals                                   | direction
//  in      | i_valid, o_ready, i_char_code            | into block
//  out     | o_valid, i_ready, o_*_mask, o_status     | out of block
//
// A closing item or star runs a pass of the shared bit-set/modulo unit,
// which sets one mask bit per cycle.
// A name's third letter walks the name table, one entry a cycle.
// Reset is synchronous; the result register holds until taken, and the next
// line's characters are accepted while it waits, except the next zero byte.
module cron_schedule_spec_parser_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [csp_pkg::CHAR_W-1:0]      i_char_code,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [csp_pkg::MIN_W-1:0]       o_minute_mask,
    output logic [csp_pkg::HOUR_W-1:0]      o_hour_mask,
    output logic [csp_pkg::DAY_W-1:0]       o_day_mask,
    output logic [csp_pkg::MON_W-1:0]       o_month_mask,
    output logic [csp_pkg::WDAY_W-1:0]      o_weekday_mask,
    output logic [csp_pkg::STATUS_W-1:0]    o_status
);

    localparam logic [3:0] PH_LEAD  = 4'd0;
    localparam logic [3:0] PH_STAR  = 4'd1;
    localparam logic [3:0] PH_SSTEP = 4'd2;
    localparam logic [3:0] PH_TOKEN = 4'd3;
    localparam logic [3:0] PH_NUM   = 4'd4;
    localparam logic [3:0] PH_NAME  = 4'd5;
    localparam logic [3:0] PH_ANAME = 4'd6;
    localparam logic [3:0] PH_STEP  = 4'd7;
    localparam logic [3:0] PH_TRAIL = 4'd8;
    localparam logic [3:0] PH_ERR   = 4'd9;

    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_SET  = 2'd1;
    localparam logic [1:0] SQ_NAME = 2'd2;

    logic [1:0]                     r_sq, n_sq;
    logic [3:0]                     r_ph, n_ph;
    logic [csp_pkg::FLD_W-1:0]      r_fld, n_fld;
    logic [csp_pkg::VAL_W-1:0]      r_v1, n_v1, r_v2, n_v2;
    logic                           r_h1, n_h1, r_h2, n_h2;
    logic [csp_pkg::NUM_W-1:0]      r_num, n_num, r_step, n_step;
    logic [23:0]                    r_name, n_name;
    logic [1:0]                     r_ncnt, n_ncnt;
    logic [3:0]                     r_nk, n_nk;
    logic [csp_pkg::ACC_W-1:0]      r_acc, n_acc;
    logic [csp_pkg::ACC_W-1:0]      r_fin [5];
    logic [csp_pkg::ACC_W-1:0]      n_fin [5];
    logic [csp_pkg::STATUS_W-1:0]   r_err, n_err;
    logic [csp_pkg::BIT_W-1:0]      r_i, n_i, r_hi, n_hi, r_pos, n_pos;
    logic [csp_pkg::CHAR_W-1:0]     r_pend, n_pend;
    logic                           r_ov, n_ov;
    logic [csp_pkg::MIN_W-1:0]      r_m0, n_m0;
    logic [csp_pkg::HOUR_W-1:0]     r_m1, n_m1;
    logic [csp_pkg::DAY_W-1:0]      r_m2, n_m2;
    logic [csp_pkg::MON_W-1:0]      r_m3, n_m3;
    logic [csp_pkg::WDAY_W-1:0]     r_m4, n_m4;
    logic [csp_pkg::STATUS_W-1:0]   r_st, n_st;

    logic                           w_acc_in;
    logic [csp_pkg::CHAR_W-1:0]     w_c;
    logic [csp_pkg::CHAR_W-1:0]     w_lc;
    logic [csp_pkg::NUM_W-1:0]      w_lo, w_hi, w_span, w_mod;
    logic [11:0]                    w_mul;
    logic [4:0]                     w_nlim;

    assign o_ready = (r_sq == SQ_IDLE) && !(r_ov && (i_char_code == csp_pkg::CH_NUL));
    assign w_acc_in = i_valid && o_ready;
    assign w_c  = i_char_code;
    assign w_lc = (w_c >= 8'd65 && w_c <= 8'd90) ? w_c + 8'd32 : w_c;
    assign w_lo = csp_pkg::fld_lo(r_fld);
    assign w_hi = csp_pkg::fld_hi(r_fld);
    assign w_span = w_hi - w_lo;
    assign w_mod  = w_span + 8'd1;
    assign w_mul  = {4'b0000, r_num} * 12'd10 + {4'b0000, w_c - csp_pkg::CH_ZERO};
    assign w_nlim = (r_fld == csp_pkg::FLD_MON) ? 5'd12 : 5'd7;

    assign o_valid        = r_ov;
    assign o_minute_mask  = r_m0;
    assign o_hour_mask    = r_m1;
    assign o_day_mask     = r_m2;
    assign o_month_mask   = r_m3;
    assign o_weekday_mask = r_m4;
    assign o_status       = r_st;

    function automatic logic blank(input logic [7:0] c);
        blank = (c == csp_pkg::CH_SPACE) || (c == csp_pkg::CH_TAB);
    endfunction

    function automatic logic digit(input logic [7:0] c);
        digit = (c >= 8'd48) && (c <= 8'd57);
    endfunction

    always_comb begin
        logic [7:0] c;
        logic       sep;
        logic [7:0] v;
        logic [7:0] lo;
        logic [7:0] hi;
        n_sq = r_sq; n_ph = r_ph; n_fld = r_fld; n_v1 = r_v1; n_v2 = r_v2;
        n_h1 = r_h1; n_h2 = r_h2; n_num = r_num; n_step = r_step;
        n_name = r_name; n_ncnt = r_ncnt; n_nk = r_nk; n_acc = r_acc;
        n_fin = r_fin; n_err = r_err; n_i = r_i; n_hi = r_hi; n_pos = r_pos;
        n_pend = r_pend; n_ov = r_ov; n_m0 = r_m0; n_m1 = r_m1; n_m2 = r_m2;
        n_m3 = r_m3; n_m4 = r_m4; n_st = r_st;
        c = w_c; sep = 1'b0; v = 8'd0; lo = 8'd0; hi = 8'd0;

        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        case (r_sq)
            SQ_SET: begin
                // one mask bit per cycle, position kept modulo field size
                if (r_i <= r_hi) begin
                    n_acc = r_acc | (64'd1 << r_pos[5:0]);
                    n_i = r_i + r_step;
                    n_pos = (r_pos + r_step >= w_mod) ? r_pos + r_step - w_mod
                                                       : r_pos + r_step;
                    if ({1'b0, r_i} + {1'b0, r_step} > 9'd255) begin
                        n_hi = 8'd0;
                        n_i = 8'd1;
                    end
                end else begin
                    c = r_pend;
                    n_sq = SQ_IDLE;
                    sep = 1'b1;
                end
            end
            SQ_NAME: begin
                if ({1'b0, r_nk} >= w_nlim) begin
                    n_err = csp_pkg::ST_NO_TOKEN;
                    n_ph = PH_ERR;
                    n_sq = SQ_IDLE;
                end else if (csp_pkg::name_of(r_fld, r_nk) == r_name) begin
                    v = {4'd0, r_nk} + w_lo;
                    n_sq = SQ_IDLE;
                    if (v > w_hi) begin
                        n_err = r_h1 ? csp_pkg::ST_SECOND : csp_pkg::ST_FIRST;
                        n_ph = PH_ERR;
                    end else begin
                        n_ph = PH_ANAME;
                        if (!r_h1) begin
                            n_v1 = v[6:0]; n_h1 = 1'b1;
                        end else begin
                            n_v2 = v[6:0]; n_h2 = 1'b1;
                        end
                    end
                end else begin
                    n_nk = r_nk + 4'd1;
                end
            end
            default: begin
                if (w_acc_in) begin
                    case (r_ph)
                        PH_LEAD, PH_TOKEN: begin
                            if (r_ph == PH_LEAD && blank(c)) begin
                                n_ph = r_ph;
                            end else if (r_ph == PH_LEAD && c == csp_pkg::CH_STAR) begin
                                n_ph = PH_STAR;
                            end else if (digit(c)) begin
                                n_num = c - csp_pkg::CH_ZERO;
                                n_ph = PH_NUM;
                            end else if (r_fld >= csp_pkg::FLD_MON && c != csp_pkg::CH_NUL) begin
                                n_name = {w_lc, 16'h0};
                                n_ncnt = 2'd1;
                                n_ph = PH_NAME;
                            end else begin
                                n_err = csp_pkg::ST_NO_TOKEN;
                                n_ph = PH_ERR;
                            end
                        end
                        PH_STAR: begin
                            if (c == csp_pkg::CH_SLASH) begin
                                n_num = 8'd0;
                                n_ph = PH_SSTEP;
                            end else begin
                                n_step = 8'd1; n_i = 8'd0; n_pos = 8'd0;
                                n_hi = w_span; n_pend = c; n_sq = SQ_SET;
                            end
                        end
                        PH_SSTEP, PH_STEP: begin
                            if (digit(c)) begin
                                n_num = (w_mul > 12'd255) ? 8'd255 : w_mul[7:0];
                            end else if (r_num == 8'd0 || r_num >= w_span) begin
                                n_step = r_num;
                                n_err = (r_ph == PH_SSTEP) ? csp_pkg::ST_STAR_STEP
                                                           : csp_pkg::ST_STEP;
                                n_ph = PH_ERR;
                            end else begin
                                n_step = r_num; n_pend = c; n_sq = SQ_SET;
                                if (r_ph == PH_SSTEP) begin
                                    n_i = 8'd0; n_pos = 8'd0; n_hi = w_span;
                                end else begin
                                    lo = {1'b0, r_v1} - w_lo;
                                    hi = !r_h2 ? lo :
                                         (r_v1 > r_v2) ? {1'b0, r_v2} - w_lo + w_mod
                                                       : {1'b0, r_v2} - w_lo;
                                    n_i = lo; n_pos = lo; n_hi = hi;
                                    n_h1 = 1'b0; n_h2 = 1'b0;
                                end
                            end
                        end
                        PH_NUM: begin
                            if (digit(c)) begin
                                n_num = (w_mul > 12'd255) ? 8'd255 : w_mul[7:0];
                            end else if (r_num < w_lo || r_num > w_hi) begin
                                n_err = r_h1 ? csp_pkg::ST_SECOND : csp_pkg::ST_FIRST;
                                n_ph = PH_ERR;
                            end else begin
                                if (!r_h1) begin
                                    n_v1 = r_num[6:0]; n_h1 = 1'b1;
                                end else begin
                                    n_v2 = r_num[6:0]; n_h2 = 1'b1;
                                end
                                if (c == csp_pkg::CH_DASH && !r_h1) begin
                                    n_ph = PH_TOKEN;
                                end else if (c == csp_pkg::CH_SLASH) begin
                                    n_num = 8'd0; n_ph = PH_STEP;
                                end else begin
                                    n_step = 8'd1; n_pend = c; n_sq = SQ_SET;
                                    lo = (r_h1 ? {1'b0, r_v1} : r_num) - w_lo;
                                    hi = !r_h1 ? lo :
                                         (r_v1 > r_num[6:0]) ? r_num - w_lo + w_mod
                                                             : r_num - w_lo;
                                    n_i = lo; n_pos = lo; n_hi = hi;
                                    n_h1 = 1'b0; n_h2 = 1'b0;
                                end
                            end
                        end
                        PH_NAME: begin
                            if (c == csp_pkg::CH_NUL) begin
                                n_err = csp_pkg::ST_NO_TOKEN;
                                n_ph = PH_ERR;
                            end else if (r_ncnt == 2'd1) begin
                                n_name[15:8] = w_lc; n_ncnt = 2'd2;
                            end else begin
                                n_name[7:0] = w_lc; n_ncnt = 2'd0;
                                n_nk = 4'd0; n_sq = SQ_NAME;
                            end
                        end
                        PH_ANAME: begin
                            if (c == csp_pkg::CH_DASH && !r_h2) begin
                                n_ph = PH_TOKEN;
                            end else if (c == csp_pkg::CH_SLASH) begin
                                n_num = 8'd0; n_ph = PH_STEP;
                            end else begin
                                n_step = 8'd1; n_pend = c; n_sq = SQ_SET;
                                lo = {1'b0, r_v1} - w_lo;
                                hi = !r_h2 ? lo :
                                     (r_v1 > r_v2) ? {1'b0, r_v2} - w_lo + w_mod
                                                   : {1'b0, r_v2} - w_lo;
                                n_i = lo; n_pos = lo; n_hi = hi;
                                n_h1 = 1'b0; n_h2 = 1'b0;
                            end
                        end
                        PH_TRAIL: begin
                            if (!blank(c) && c != csp_pkg::CH_NUL) begin
                                n_err = csp_pkg::ST_SEP; n_ph = PH_ERR;
                            end
                        end
                        default: begin
                            n_ph = r_ph;
                        end
                    endcase
                end
            end
        endcase

        // close the item or field after the bit-set pass
        if (sep) begin
            if (c == csp_pkg::CH_COMMA && r_ph != PH_STAR && r_ph != PH_SSTEP) begin
                n_ph = PH_TOKEN;
            end else begin
                n_fin[r_fld] = n_acc;
                if (r_fld < csp_pkg::FLD_WDAY) begin
                    if (blank(c)) begin
                        n_fld = r_fld + 3'd1; n_acc = 64'd0;
                        n_h1 = 1'b0; n_h2 = 1'b0; n_ph = PH_LEAD;
                    end else begin
                        n_err = csp_pkg::ST_SEP; n_ph = PH_ERR;
                    end
                end else if (blank(c) || c == csp_pkg::CH_NUL) begin
                    n_ph = PH_TRAIL;
                end else begin
                    n_err = csp_pkg::ST_SEP; n_ph = PH_ERR;
                end
            end
        end

        // end of line: emit once the closing pass is done, then clear
        if (c == csp_pkg::CH_NUL && n_sq == SQ_IDLE &&
            ((sep) || (w_acc_in && r_sq == SQ_IDLE))) begin
            n_ov = 1'b1;
            n_m0 = n_fin[0][csp_pkg::MIN_W-1:0];
            n_m1 = n_fin[1][csp_pkg::HOUR_W-1:0];
            n_m2 = n_fin[2][csp_pkg::DAY_W-1:0];
            n_m3 = n_fin[3][csp_pkg::MON_W-1:0];
            n_m4 = n_fin[4][csp_pkg::WDAY_W-1:0];
            n_st = n_err;
            n_ph = PH_LEAD; n_fld = csp_pkg::FLD_MIN; n_h1 = 1'b0; n_h2 = 1'b0;
            n_num = 8'd0; n_step = 8'd0; n_acc = 64'd0; n_err = csp_pkg::ST_OK;
            n_ncnt = 2'd0; n_name = 24'h0;
            for (int k = 0; k < 5; k++) n_fin[k] = 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq <= SQ_IDLE; r_ph <= PH_LEAD; r_fld <= csp_pkg::FLD_MIN;
            r_h1 <= 1'b0; r_h2 <= 1'b0; r_num <= 8'd0; r_step <= 8'd0;
            r_name <= 24'h0; r_ncnt <= 2'd0; r_acc <= 64'd0;
            for (int k = 0; k < 5; k++) r_fin[k] <= 64'd0;
            r_err <= csp_pkg::ST_OK; r_ov <= 1'b0;
        end else begin
            r_sq <= n_sq; r_ph <= n_ph; r_fld <= n_fld; r_h1 <= n_h1; r_h2 <= n_h2;
            r_num <= n_num; r_step <= n_step; r_name <= n_name; r_ncnt <= n_ncnt;
            r_acc <= n_acc; r_fin <= n_fin; r_err <= n_err; r_ov <= n_ov;
        end
        r_v1 <= n_v1; r_v2 <= n_v2; r_nk <= n_nk; r_i <= n_i; r_hi <= n_hi;
        r_pos <= n_pos; r_pend <= n_pend; r_m0 <= n_m0; r_m1 <= n_m1;
        r_m2 <= n_m2; r_m3 <= n_m3; r_m4 <= n_m4; r_st <= n_st;
    end

endmodule

[src/csp_checker.sv]
// Port-level checks for the cron line parser, bound to the top level.
module csp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic [csp_pkg::CHAR_W-1:0]      i_char_code,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [csp_pkg::STATUS_W-1:0]    o_status,
    input logic [csp_pkg::WDAY_W-1:0]      o_weekday_mask
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_weekday_mask))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= csp_pkg::ST_SEP)
        else $error("status out of range");

    a_nul_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready && i_valid && i_char_code == csp_pkg::CH_NUL |-> !o_ready)
        else $error("end of line taken while result waits");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");

endmodule

bind cron_schedule_spec_parser_top csp_checker u_csp_checker (.*);
